// File: hdl/stpc_pkg.sv
package stpc_pkg;

  // Window and sample geometry
  localparam int WINDOW      = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int AW          = $clog2(WINDOW);
  localparam int CW          = $clog2(WINDOW + 1);
  localparam int DW          = SAMPLE_BITS + 1;

  // Field and state widths
  localparam int STEP_W   = 17;
  localparam int SUM_W    = 41;
  localparam int COUNT_W  = 24;
  localparam int THR_W    = 18;
  localparam int RATE_W   = 16;
  localparam int GUARD_W  = 17;
  localparam int LEARN_W  = 24;
  localparam int LIMIT_W  = 16;
  localparam int PERIOD_W = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 2;
  localparam int WIDE_W   = (DW > STEP_W) ? DW : STEP_W;
  localparam int CMP_W    = ((WIDE_W > THR_W) ? WIDE_W : THR_W) + 1;

  // Threshold divider: |sum * 9| over 2 * count
  localparam int SUM9_W = SUM_W + 4;
  localparam int QW     = SUM_W + 3;
  localparam int DVW    = COUNT_W + 1;
  localparam int DCW    = $clog2(QW);

  localparam int THR_MAX = 131071;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LEARN_TIME  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;
  localparam logic [IDX_W-1:0] REG_GUARD       = 2'd2;
  localparam logic [IDX_W-1:0] REG_PERIOD      = 2'd3;

  // Mode codes
  localparam logic [1:0] MODE_LEARN  = 2'd0;
  localparam logic [1:0] MODE_DETECT = 2'd1;
  localparam logic [1:0] MODE_IGNORE = 2'd2;
  localparam logic [1:0] MODE_PACE   = 2'd3;

  // Pace request levels
  localparam logic [1:0] PACE_NONE = 2'd0;
  localparam logic [1:0] PACE_REQ  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic walk_run;
    logic update;
    logic div_start;
    logic div_step;
    logic thr_write;
    logic out_load;
  } stpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic need_thr;
    logic div_done;
  } stpc_status_t;

endpackage

// File: hdl/slope_threshold_pacing_controller.sv
// Slope-threshold pacing controller. Each input transaction carries one sample and its
// millisecond timestamp and yields exactly one result transaction. The sample is written
// into a 64-entry window memory, and the window is then walked oldest to newest through
// the single read port to find the steepest falling step. The next sample is accepted only
// after the result has been loaded into the output register, and that load waits while the
// output is stalled. The first transaction after the learning time also runs the bit-serial
// threshold divider, one quotient bit per cycle. A new sample is accepted while the previous
// result still waits in the output register. Configuration registers are written through
// cfg_write_en / cfg_index / cfg_data and are meant to change only while the block is idle.
module slope_threshold_pacing_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [stpc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [stpc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  sample,
  input  logic [stpc_pkg::TIME_W-1:0]         time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          pace_request,
  output logic [1:0]                          mode,
  output logic                                activation_seen,
  output logic                                threshold_ready,
  output logic signed [stpc_pkg::STEP_W-1:0]  lowest_step
);

  stpc_pkg::stpc_cmd_t    cmd;
  stpc_pkg::stpc_status_t st;

  // Sequencer
  stpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Window, accumulator, divider and pacing state
  stpc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample          (sample),
    .time_ms         (time_ms),
    .pace_request    (pace_request),
    .mode            (mode),
    .activation_seen (activation_seen),
    .threshold_ready (threshold_ready),
    .lowest_step     (lowest_step)
  );

endmodule

// File: hdl/stpc_ctrl.sv
module stpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  stpc_pkg::stpc_status_t st,
  output stpc_pkg::stpc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequencing of one transaction
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_run = 1'b1;
        if (st.walk_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.need_thr) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.update = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.thr_write = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/stpc_dp.sv
module stpc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stpc_pkg::stpc_cmd_t                   cmd,
  output stpc_pkg::stpc_status_t                st,
  input  logic                                  cfg_write_en,
  input  logic [stpc_pkg::IDX_W-1:0]            cfg_index,
  input  logic [stpc_pkg::CFG_W-1:0]            cfg_data,
  input  logic signed [15:0]                    sample,
  input  logic [stpc_pkg::TIME_W-1:0]           time_ms,
  output logic [1:0]                            pace_request,
  output logic [1:0]                            mode,
  output logic                                  activation_seen,
  output logic                                  threshold_ready,
  output logic signed [stpc_pkg::STEP_W-1:0]    lowest_step
);

  localparam int WINDOW   = stpc_pkg::WINDOW;
  localparam int SB       = stpc_pkg::SAMPLE_BITS;
  localparam int AW       = stpc_pkg::AW;
  localparam int CW       = stpc_pkg::CW;
  localparam int DW       = stpc_pkg::DW;
  localparam int SUM_W    = stpc_pkg::SUM_W;
  localparam int COUNT_W  = stpc_pkg::COUNT_W;
  localparam int THR_W    = stpc_pkg::THR_W;
  localparam int RATE_W   = stpc_pkg::RATE_W;
  localparam int GUARD_W  = stpc_pkg::GUARD_W;
  localparam int PERIOD_W = stpc_pkg::PERIOD_W;
  localparam int SUM9_W   = stpc_pkg::SUM9_W;
  localparam int QW       = stpc_pkg::QW;
  localparam int DVW      = stpc_pkg::DVW;
  localparam int DCW      = stpc_pkg::DCW;
  localparam int WIDE_W   = stpc_pkg::WIDE_W;
  localparam int CMP_W    = stpc_pkg::CMP_W;

  // Configuration registers
  logic [stpc_pkg::LEARN_W-1:0] learn_time;
  logic [stpc_pkg::LIMIT_W-1:0] lower_limit;
  logic [stpc_pkg::LIMIT_W-1:0] guard_interval;
  logic [PERIOD_W-1:0]          sample_period;

  // Window storage
  logic [SB-1:0]           window_mem [WINDOW];
  logic [AW-1:0]           head;
  logic [CW-1:0]           fill;
  logic [stpc_pkg::TIME_W-1:0] time_q;

  // Window walk
  logic [CW-1:0]           rd_idx;
  logic [AW-1:0]           rd_idx_q;
  logic                    rd_vld;
  logic                    rd_mask;
  logic [SB-1:0]           rd_data;
  logic signed [SB-1:0]    prev;
  logic signed [SB-1:0]    cur;
  logic signed [DW-1:0]    diff;
  logic signed [DW-1:0]    min_step;
  logic                    issue;
  logic [AW:0]             addr_sum;
  logic [AW-1:0]           rd_addr;
  logic                    pos_ok;

  // Controller state of the model
  logic signed [SUM_W-1:0]   slope_sum;
  logic [COUNT_W-1:0]        slope_count;
  logic signed [THR_W-1:0]   detect_thr;
  logic                      thr_valid;
  logic [RATE_W-1:0]         rate_timer;
  logic signed [GUARD_W-1:0] guard_timer;
  logic                      act_flag;
  logic [1:0]                pace_level;
  logic [1:0]                mode_code;

  // Divider
  logic [QW-1:0]             div_q;
  logic [DVW-1:0]            div_rem;
  logic [DCW-1:0]            div_cnt;
  logic                      div_neg;
  logic                      div_zero;
  logic signed [SUM9_W-1:0]  sum9;
  logic signed [SUM9_W-1:0]  sum9_mag;
  logic [DVW-1:0]            divisor;
  logic [DVW:0]              div_shift;
  logic [DVW:0]              div_sub;
  logic                      div_ge;

  // Decision terms
  logic                      learning;
  logic signed [SUM_W:0]     sum_add;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [WIDE_W-1:0]  step_wide;
  logic signed [CMP_W-1:0]   step_cmp;
  logic signed [CMP_W-1:0]   thr_cmp;
  logic                      go;
  logic                      hit;
  logic                      guard_le0;
  logic [RATE_W:0]           rate_add;
  logic [RATE_W-1:0]         rate_adv;
  logic signed [GUARD_W:0]   guard_sub;
  logic signed [GUARD_W-1:0] guard_adv;
  logic signed [GUARD_W-1:0] guard_load;
  logic [THR_W-1:0]          q_low;
  logic signed [THR_W-1:0]   thr_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_time     <= '0;
      lower_limit    <= '0;
      guard_interval <= '0;
      sample_period  <= PERIOD_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        stpc_pkg::REG_LEARN_TIME:  learn_time     <= cfg_data[stpc_pkg::LEARN_W-1:0];
        stpc_pkg::REG_LOWER_LIMIT: lower_limit    <= cfg_data[stpc_pkg::LIMIT_W-1:0];
        stpc_pkg::REG_GUARD:       guard_interval <= cfg_data[stpc_pkg::LIMIT_W-1:0];
        stpc_pkg::REG_PERIOD:      sample_period  <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring: head is the write slot, oldest once full; fill counts written slots
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.accept) begin
      head <= (head == AW'(WINDOW - 1)) ? '0 : head + 1'b1;
      if (fill != CW'(WINDOW)) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) time_q <= time_ms;
  end

  // Read address of window position rd_idx, oldest first
  assign issue    = cmd.walk_run && (rd_idx != CW'(WINDOW));
  assign addr_sum = {1'b0, head} + {1'b0, rd_idx[AW-1:0]};
  assign rd_addr  = (addr_sum >= (AW + 1)'(WINDOW)) ?
                    AW'(addr_sum - (AW + 1)'(WINDOW)) : addr_sum[AW-1:0];
  // Slots never written read as zero
  assign pos_ok   = ({1'b0, rd_idx} + {1'b0, fill}) >= (CW + 1)'(WINDOW);

  // Window memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.accept) window_mem[head] <= sample[SB-1:0];
    if (issue) begin
      rd_data  <= window_mem[rd_addr];
      rd_mask  <= pos_ok;
      rd_idx_q <= rd_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) rd_idx <= rd_idx + 1'b1;
    end
  end

  // Adjacent difference and running minimum
  assign cur  = rd_mask ? signed'(rd_data) : '0;
  assign diff = DW'(cur) - DW'(prev);

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev <= cur;
      if (rd_idx_q == AW'(1)) begin
        min_step <= diff;
      end else if ((rd_idx_q != '0) && (diff < min_step)) begin
        min_step <= diff;
      end
    end
  end

  assign st.walk_done = rd_vld && (rd_idx_q == AW'(WINDOW - 1));

  // Phase selection
  assign learning    = time_q < stpc_pkg::TIME_W'(learn_time);
  assign st.need_thr = !learning && !thr_valid;

  // Learning accumulation with saturation
  assign sum_add = (SUM_W + 1)'(slope_sum) + (SUM_W + 1)'(min_step);
  assign sum_sat = (sum_add[SUM_W] != sum_add[SUM_W-1]) ?
                   {sum_add[SUM_W], {(SUM_W - 1){~sum_add[SUM_W]}}} :
                   sum_add[SUM_W-1:0];

  // Pacing terms
  assign step_wide = WIDE_W'(min_step);
  assign step_cmp  = CMP_W'(min_step);
  assign thr_cmp   = CMP_W'(detect_thr);
  assign hit       = step_cmp < thr_cmp;
  assign go        = (rate_timer <= lower_limit) || (pace_level == stpc_pkg::PACE_REQ);
  assign guard_le0 = guard_timer[GUARD_W-1] || (guard_timer == '0);

  assign rate_add  = {1'b0, rate_timer} + (RATE_W + 1)'(sample_period);
  assign rate_adv  = rate_add[RATE_W] ? '1 : rate_add[RATE_W-1:0];
  assign guard_sub = (GUARD_W + 1)'(guard_timer) - (GUARD_W + 1)'(sample_period);
  assign guard_adv = (guard_sub[GUARD_W] != guard_sub[GUARD_W-1]) ?
                     {1'b1, {(GUARD_W - 1){1'b0}}} : guard_sub[GUARD_W-1:0];
  assign guard_load = signed'({1'b0, guard_interval});

  // Divider operands
  assign sum9     = (SUM9_W'(slope_sum) <<< 3) + SUM9_W'(slope_sum);
  assign sum9_mag = sum9[SUM9_W-1] ? -sum9 : sum9;
  assign divisor  = {slope_count, 1'b0};
  assign div_shift = {div_rem, div_q[QW-1]};
  assign div_sub   = div_shift - {1'b0, divisor};
  assign div_ge    = div_shift >= {1'b0, divisor};
  assign st.div_done = div_cnt == DCW'(QW - 1);

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q    <= sum9_mag[QW-1:0];
      div_rem  <= '0;
      div_cnt  <= '0;
      div_neg  <= sum9[SUM9_W-1];
      div_zero <= (slope_count == '0);
    end else if (cmd.div_step) begin
      div_q   <= {div_q[QW-2:0], div_ge};
      div_rem <= div_ge ? div_sub[DVW-1:0] : div_shift[DVW-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Signed, saturated threshold
  assign q_low = div_q[THR_W-1:0];
  always_comb begin
    if (div_zero) begin
      thr_new = '0;
    end else if (div_neg) begin
      thr_new = (div_q > QW'(stpc_pkg::THR_MAX + 1)) ?
                {1'b1, {(THR_W - 1){1'b0}}} : -signed'(q_low);
    end else begin
      thr_new = (div_q > QW'(stpc_pkg::THR_MAX)) ?
                {1'b0, {(THR_W - 1){1'b1}}} : signed'(q_low);
    end
  end

  // Per-transaction state update
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_sum   <= '0;
      slope_count <= '0;
      detect_thr  <= '0;
      thr_valid   <= 1'b0;
      rate_timer  <= '0;
      guard_timer <= '0;
      act_flag    <= 1'b0;
      pace_level  <= stpc_pkg::PACE_NONE;
      mode_code   <= stpc_pkg::MODE_LEARN;
    end else if (cmd.thr_write) begin
      detect_thr <= thr_new;
      thr_valid  <= 1'b1;
      mode_code  <= stpc_pkg::MODE_LEARN;
    end else if (cmd.update) begin
      if (learning) begin
        mode_code <= stpc_pkg::MODE_LEARN;
        if (slope_count != '1) begin
          slope_sum   <= sum_sat;
          slope_count <= slope_count + 1'b1;
        end
      end else if (go && !act_flag) begin
        mode_code <= stpc_pkg::MODE_DETECT;
        if (hit) begin
          rate_timer  <= '0;
          guard_timer <= guard_load;
          pace_level  <= stpc_pkg::PACE_NONE;
          act_flag    <= 1'b1;
        end else begin
          rate_timer  <= rate_adv;
          guard_timer <= guard_adv;
        end
      end else if (go) begin
        if (hit && guard_le0) begin
          mode_code   <= stpc_pkg::MODE_DETECT;
          rate_timer  <= '0;
          guard_timer <= guard_load;
          pace_level  <= stpc_pkg::PACE_NONE;
        end else begin
          mode_code   <= guard_le0 ? stpc_pkg::MODE_DETECT : stpc_pkg::MODE_IGNORE;
          rate_timer  <= rate_adv;
          guard_timer <= guard_adv;
        end
      end else begin
        mode_code  <= stpc_pkg::MODE_PACE;
        pace_level <= stpc_pkg::PACE_REQ;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pace_request    <= pace_level;
      mode            <= mode_code;
      activation_seen <= act_flag;
      threshold_ready <= thr_valid;
      lowest_step     <= step_wide[stpc_pkg::STEP_W-1:0];
    end
  end

endmodule

// File: hdl/stpc_checker.sv
module stpc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         pace_request,
  input logic [1:0]                         mode,
  input logic                               activation_seen,
  input logic                               threshold_ready,
  input logic signed [stpc_pkg::STEP_W-1:0] lowest_step
);

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // An accepted transaction keeps the input stalled while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lowest_step) && $stable(mode))
    else $error("stalled result changed");

  // Detecting, ignoring and pacing modes exist only with a threshold
  a_mode_needs_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode != stpc_pkg::MODE_LEARN) |-> threshold_ready)
    else $error("non-learning mode without threshold");

  // Activation and pace requests only come from the pacing logic
  a_pacing_needs_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (activation_seen || (pace_request == stpc_pkg::PACE_REQ)) |->
    threshold_ready)
    else $error("pacing output without threshold");

endmodule

bind slope_threshold_pacing_controller stpc_checker u_stpc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .pace_request    (pace_request),
  .mode            (mode),
  .activation_seen (activation_seen),
  .threshold_ready (threshold_ready),
  .lowest_step     (lowest_step)
);
